// File: rtl/s2a_pkg.sv
// shared types, constants and key map for the scan code to ascii fifo
`timescale 1ns / 1ps
package s2a_pkg;

  localparam int unsigned FifoDepthDefault = 4096;
  localparam int unsigned CountW = 12;
  localparam int unsigned CharW = 7;

  localparam logic [7:0] ScReleaseBit   = 8'h80;
  localparam logic [7:0] ScLshiftPress  = 8'h2A;
  localparam logic [7:0] ScRshiftPress  = 8'h36;
  localparam logic [7:0] ScCapsPress    = 8'h3A;
  localparam logic [7:0] ScLshiftRelease = 8'hAA;
  localparam logic [7:0] ScRshiftRelease = 8'hB6;
  localparam logic [CharW-1:0] CaseOffset = 7'd32;
  localparam logic [CharW-1:0] LowerA = 7'h61;
  localparam logic [CharW-1:0] LowerZ = 7'h7A;

  localparam logic CmdScancode = 1'b0;
  localparam logic CmdRead     = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] scancode;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0]  char_out;
    logic              char_valid;
    logic              char_stored;
    logic              dropped_full;
    logic              caps_lock_on;
    logic [CountW-1:0] fifo_count;
  } out_word_t;

  typedef struct packed {
    logic             has_char;
    logic [CharW-1:0] chr;
    logic             caps;
  } dec_res_t;

  function automatic logic [CharW-1:0] key_map(input logic [6:0] code);
    logic [CharW-1:0] c;
    unique case (code)
      7'd9:  c = 7'h5F;
      7'd14: c = 7'h08;
      7'd16: c = 7'h61;
      7'd17: c = 7'h7A;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h71;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h6D;
      7'd44: c = 7'h77;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd52: c = 7'h2F;
      7'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/s2a_mem.sv
// character store: one write port, one registered read port
`timescale 1ns / 1ps
module s2a_mem #(
  parameter int unsigned FIFO_DEPTH = s2a_pkg::FifoDepthDefault,
  parameter int unsigned AW = $clog2(FIFO_DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [s2a_pkg::CharW-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [s2a_pkg::CharW-1:0] rdata
);
  import s2a_pkg::*;

  logic [CharW-1:0] store [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

// File: rtl/s2a_dec.sv
// scan code decoder: shift and caps flags, key map and case folding
`timescale 1ns / 1ps
module s2a_dec (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  s2a_pkg::in_word_t word,
  output s2a_pkg::dec_res_t res
);
  import s2a_pkg::*;

  logic caps, lshift, rshift;
  logic caps_next, lshift_next, rshift_next;
  logic [CharW-1:0] mapped;
  logic upper;

  always_comb begin
    caps_next   = caps;
    lshift_next = lshift;
    rshift_next = rshift;
    if (word.command == CmdScancode) begin
      if ((word.scancode & ScReleaseBit) != 8'h00) begin
        if (word.scancode == ScLshiftRelease) begin
          lshift_next = 1'b0;
        end else if (word.scancode == ScRshiftRelease) begin
          rshift_next = 1'b0;
        end
      end else begin
        if (word.scancode == ScCapsPress) begin
          caps_next = !caps;
        end else if (word.scancode == ScLshiftPress) begin
          lshift_next = 1'b1;
        end else if (word.scancode == ScRshiftPress) begin
          rshift_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    mapped = key_map(word.scancode[6:0]);
    upper  = caps_next ^ (lshift_next | rshift_next);
    res.has_char = (word.command == CmdScancode) && !word.scancode[7] && (mapped != '0);
    res.chr      = (upper && mapped >= LowerA && mapped <= LowerZ) ? mapped - CaseOffset
                                                                   : mapped;
    res.caps     = caps_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      caps   <= 1'b0;
      lshift <= 1'b0;
      rshift <= 1'b0;
    end else if (en) begin
      caps   <= caps_next;
      lshift <= lshift_next;
      rshift <= rshift_next;
    end
  end

endmodule

// File: rtl/scancode_to_ascii_fifo_top.sv
// top level: set 1 keyboard decoder feeding a character ring fifo
//
// request channel (req_valid, req_stall, req): each word is either a scan
// code byte (command 0) or a request for the next queued character
// (command 1). response channel (rsp_valid, rsp_stall, rsp): exactly one
// response word per request word, in order.
// response path: an accepted request is registered in the middle stage,
// with the character store read registering at the accept edge, and then
// in the output register; while the response stalls it waits in the middle stage.
// throughput: one word per cycle while req_stall is low; pointers, count and flags
// update in the accept cycle and the store is written or read at that same edge.
// a full fifo holds FIFO_DEPTH-1 characters; further characters are dropped
// and flagged. a read on an empty fifo returns char_valid 0.
// reset clears pointers, count, shift and caps flags and both pipeline
// stages; the store itself is not cleared and no clearing pass is needed.
// when rsp_stall is high the response holds, the middle stage fills and
// req_stall is high in every cycle the middle stage holds a word it cannot pass on.
`timescale 1ns / 1ps
module scancode_to_ascii_fifo_top #(
  parameter int unsigned FIFO_DEPTH = s2a_pkg::FifoDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  s2a_pkg::in_word_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output s2a_pkg::out_word_t rsp
);
  import s2a_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0] Last = AW'(FIFO_DEPTH - 1);

  logic          accept, ready;
  logic          s1_adv;
  dec_res_t      dec;
  logic [AW-1:0] wp, rp, count;
  logic [AW-1:0] wp_next, rp_next, count_next;
  logic          full, empty;
  logic          mem_we, mem_re;
  logic [CharW-1:0] mem_rdata;
  logic [31:0]   count_ext;

  logic          s1_valid, s1_rd, s1_stored, s1_dropped, s1_caps;
  logic [CountW-1:0] s1_count;

  assign s1_adv    = !rsp_valid || !rsp_stall;
  assign ready     = !s1_valid || s1_adv;
  assign req_stall = !ready;
  assign accept    = req_valid && ready;

  assign full  = (count == Last);
  assign empty = (count == '0);

  assign mem_we = accept && dec.has_char && !full;
  assign mem_re = accept && (req.command == CmdRead) && !empty;

  always_comb begin
    wp_next    = wp;
    rp_next    = rp;
    count_next = count;
    if (mem_we) begin
      wp_next    = (wp == Last) ? '0 : wp + AW'(1);
      count_next = count + AW'(1);
    end
    if (mem_re) begin
      rp_next    = (rp == Last) ? '0 : rp + AW'(1);
      count_next = count - AW'(1);
    end
  end

  assign count_ext = 32'(count_next);

  s2a_dec u_dec (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .word (req),
    .res  (dec)
  );

  s2a_mem #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (dec.chr),
    .re    (mem_re),
    .raddr (rp),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd      <= mem_re;
      s1_stored  <= mem_we;
      s1_dropped <= dec.has_char && full;
      s1_caps    <= dec.caps;
      s1_count   <= count_ext[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      rsp.char_out     <= s1_rd ? mem_rdata : '0;
      rsp.char_valid   <= s1_rd;
      rsp.char_stored  <= s1_stored;
      rsp.dropped_full <= s1_dropped;
      rsp.caps_lock_on <= s1_caps;
      rsp.fifo_count   <= s1_count;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= Last)
    else $error("fifo count beyond capacity");

  a_one_port: assert property (@(posedge clk) disable iff (rst) !(mem_we && mem_re))
    else $error("store written and read by one word");

  a_write_fills: assert property (@(posedge clk) disable iff (rst) mem_we |=> count != '0)
    else $error("count zero after a store write");

  a_rsp_kind: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && rsp.char_valid |-> !rsp.char_stored && !rsp.dropped_full)
    else $error("read response carries store flags");

endmodule
